// ===== sv/sbr_pkg.sv =====
// shared types, constants and bone table for the bone retarget block
`timescale 1ns / 1ps
package sbr_pkg;
  localparam int JOINTS = 18;
  localparam int BONES = 17;
  localparam int COORD_BITS = 12;
  localparam int NECK = 1;
  localparam int SEARCH_BITS = 18;
  localparam int JIDX_W = 5;
  localparam int BIDX_W = 5;

  localparam logic OP_TARGET = 1'b0;
  localparam logic OP_REFERENCE = 1'b1;

  typedef logic [JIDX_W-1:0] jidx_t;

  function automatic jidx_t bone_parent(input logic [BIDX_W-1:0] b);
    case (b)
      5'd0, 5'd3, 5'd6, 5'd12: bone_parent = 5'd1;
      5'd1: bone_parent = 5'd2;
      5'd2: bone_parent = 5'd3;
      5'd4: bone_parent = 5'd5;
      5'd5: bone_parent = 5'd6;
      5'd7: bone_parent = 5'd11;
      5'd8: bone_parent = 5'd12;
      5'd9: bone_parent = 5'd11;
      5'd10: bone_parent = 5'd8;
      5'd11: bone_parent = 5'd9;
      5'd13, 5'd15: bone_parent = 5'd0;
      5'd14: bone_parent = 5'd14;
      5'd16: bone_parent = 5'd15;
      default: bone_parent = 5'd0;
    endcase
  endfunction

  function automatic jidx_t bone_child(input logic [BIDX_W-1:0] b);
    case (b)
      5'd0: bone_child = 5'd2;
      5'd1: bone_child = 5'd3;
      5'd2: bone_child = 5'd4;
      5'd3: bone_child = 5'd5;
      5'd4: bone_child = 5'd6;
      5'd5: bone_child = 5'd7;
      5'd6: bone_child = 5'd11;
      5'd7: bone_child = 5'd12;
      5'd8: bone_child = 5'd13;
      5'd9: bone_child = 5'd8;
      5'd10: bone_child = 5'd9;
      5'd11: bone_child = 5'd10;
      5'd12: bone_child = 5'd0;
      5'd13: bone_child = 5'd14;
      5'd14: bone_child = 5'd16;
      5'd15: bone_child = 5'd15;
      5'd16: bone_child = 5'd17;
      default: bone_child = 5'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) sat16 = 16'sh7fff;
    else if (v < -18'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction
endpackage

// ===== sv/sbr_len_search.sv =====
// bit-serial search for the rounded scaled bone component length
`timescale 1ns / 1ps
module sbr_len_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] comp,
  input  logic [25:0] tlen,
  input  logic [25:0] dlen,
  output logic        done,
  output logic [17:0] result
);
  import sbr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RHS0, S_RHS1, S_TRY, S_M1, S_M2} st_t;

  st_t         st_r;
  logic [4:0]  bit_r;
  logic [17:0] n_r;
  logic [25:0] csq_r;
  logic [53:0] rhs_r;
  logic [37:0] oddsq_r;
  logic [44:0] mlo_r;
  logic [44:0] mhi_r;
  logic [12:0] comp_r;
  logic [25:0] t_r, d_r;
  logic [17:0] cand;
  logic [18:0] odd;
  logic [63:0] lhs;

  assign cand = n_r | (18'd1 << bit_r);
  assign odd = {cand, 1'b0} - 19'd1;
  assign lhs = {19'd0, mlo_r} + {mhi_r, 19'd0};

  // product split into two 19-bit halves of odd^2 times d
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          comp_r <= comp;
          t_r <= tlen;
          d_r <= dlen;
          n_r <= '0;
          bit_r <= 5'(SEARCH_BITS - 1);
          st_r <= S_RHS0;
        end
        S_RHS0: begin
          csq_r <= 26'(comp_r * comp_r);
          st_r <= S_RHS1;
        end
        S_RHS1: begin
          rhs_r <= {28'd0, csq_r} * {28'd0, t_r};
          st_r <= S_TRY;
        end
        S_TRY: begin
          oddsq_r <= 38'(odd * odd);
          st_r <= S_M1;
        end
        S_M1: begin
          mlo_r <= {26'd0, oddsq_r[18:0]} * {19'd0, d_r};
          mhi_r <= {26'd0, oddsq_r[37:19]} * {19'd0, d_r};
          st_r <= S_M2;
        end
        S_M2: begin
          if (lhs <= {8'd0, rhs_r, 2'b00}) n_r <= cand;
          if (bit_r == 5'd0) begin
            st_r <= S_IDLE;
            done <= 1'b1;
          end else begin
            bit_r <= bit_r - 5'd1;
            st_r <= S_TRY;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign result = n_r;
endmodule

// ===== sv/skeleton_bone_retarget.sv =====
// top level: joint stores, bone sequencer and result emitter
// sequence: after the frame_end transaction, a root step, then for each of the 17 bones fetch,
// square, sum, two length searches on the shared search unit and add, then a shift step
// flow: loads are accepted while idle; a frame_end transaction holds ready low, also through
// any result stalls, until all 18 results are taken
// reset: synchronous active low, clears sequencer only; joint stores hold anything
`timescale 1ns / 1ps
module skeleton_bone_retarget (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [4:0]  in_joint_index,
  input  logic [11:0] in_joint_x,
  input  logic [11:0] in_joint_y,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_index,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic        out_last
);
  import sbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_FETCH, S_DIFF, S_SQ, S_SUM, S_SX, S_WX, S_SY, S_WY, S_ADD,
    S_SHIFT, S_EMIT
  } st_t;

  logic [23:0] tgt_mem [JOINTS];
  logic [23:0] ref_mem [JOINTS];
  logic signed [15:0] rbx_mem [JOINTS];
  logic signed [15:0] rby_mem [JOINTS];

  st_t st_r;
  logic [4:0] bone_r, k_r;
  logic signed [12:0] dx_r, dy_r, tx_r, ty_r;
  logic [25:0] dxs_r, dys_r, txs_r, tys_r, t_r, d_r;
  logic [17:0] ox_r, oy_r;
  logic signed [16:0] shx_r, shy_r;
  logic srch_start;
  logic srch_done;
  logic [12:0] srch_comp;
  logic [25:0] srch_d;
  logic [17:0] srch_res;
  jidx_t par, chd;
  logic signed [18:0] nx, ny;

  assign par = bone_parent(bone_r);
  assign chd = bone_child(bone_r);

  sbr_len_search u_search (
    .clk(clk), .rst_n(rst_n), .start(srch_start), .comp(srch_comp),
    .tlen(t_r), .dlen(srch_d), .done(srch_done), .result(srch_res)
  );

  always_comb begin
    srch_start = (st_r == S_SX) || (st_r == S_SY);
    srch_d = (d_r == 26'd0) ? 26'd1 : d_r;
    if (d_r == 26'd0) srch_comp = (st_r == S_SY) ? 13'd1 : 13'd0;
    else if (st_r == S_SX) srch_comp = dx_r[12] ? 13'(-dx_r) : dx_r;
    else srch_comp = dy_r[12] ? 13'(-dy_r) : dy_r;
  end

  assign in_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_joint_index < 5'(JOINTS)) begin
      if (in_operation == OP_TARGET) tgt_mem[in_joint_index] <= {in_joint_x, in_joint_y};
      else ref_mem[in_joint_index] <= {in_joint_x, in_joint_y};
    end
  end

  always_comb begin
    nx = 19'(rbx_mem[par]) + (dx_r[12] ? -$signed({1'b0, ox_r}) : $signed({1'b0, ox_r}));
    ny = 19'(rby_mem[par]) + (dy_r[12] && d_r != 0 ? -$signed({1'b0, oy_r})
                                                    : $signed({1'b0, oy_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid && in_operation == OP_REFERENCE && in_frame_end) begin
          st_r <= S_ROOT;
        end
        S_ROOT: begin
          rbx_mem[NECK] <= 16'({4'd0, ref_mem[NECK][23:12]});
          rby_mem[NECK] <= 16'({4'd0, ref_mem[NECK][11:0]});
          bone_r <= '0;
          st_r <= S_FETCH;
        end
        S_FETCH: begin
          dx_r <= $signed({1'b0, ref_mem[chd][23:12]}) - $signed({1'b0, ref_mem[par][23:12]});
          dy_r <= $signed({1'b0, ref_mem[chd][11:0]}) - $signed({1'b0, ref_mem[par][11:0]});
          tx_r <= $signed({1'b0, tgt_mem[chd][23:12]}) - $signed({1'b0, tgt_mem[par][23:12]});
          ty_r <= $signed({1'b0, tgt_mem[chd][11:0]}) - $signed({1'b0, tgt_mem[par][11:0]});
          st_r <= S_SQ;
        end
        S_SQ: begin
          dxs_r <= 26'(dx_r * dx_r);
          dys_r <= 26'(dy_r * dy_r);
          txs_r <= 26'(tx_r * tx_r);
          tys_r <= 26'(ty_r * ty_r);
          st_r <= S_SUM;
        end
        S_SUM: begin
          d_r <= dxs_r + dys_r;
          t_r <= txs_r + tys_r;
          st_r <= S_SX;
        end
        S_SX: st_r <= S_WX;
        S_WX: if (srch_done) begin
          ox_r <= (d_r == 0) ? 18'd0 : srch_res;
          st_r <= S_SY;
        end
        S_SY: st_r <= S_WY;
        S_WY: if (srch_done) begin
          oy_r <= srch_res;
          st_r <= S_ADD;
        end
        S_ADD: begin
          rbx_mem[chd] <= sat16(nx[17:0] | {18{nx[18] & ~nx[17]}} & 18'h20000);
          rby_mem[chd] <= sat16(ny[17:0] | {18{ny[18] & ~ny[17]}} & 18'h20000);
          if (bone_r == 5'(BONES - 1)) st_r <= S_SHIFT;
          else begin
            bone_r <= bone_r + 5'd1;
            st_r <= S_FETCH;
          end
        end
        S_SHIFT: begin
          shx_r <= $signed({5'd0, tgt_mem[NECK][23:12]}) - 17'(rbx_mem[NECK]);
          shy_r <= $signed({5'd0, tgt_mem[NECK][11:0]}) - 17'(rby_mem[NECK]);
          k_r <= '0;
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_last) begin
              out_valid <= 1'b0;
              st_r <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_index <= k_r;
              out_x <= sat16(18'(rbx_mem[k_r]) + 18'(shx_r));
              out_y <= sat16(18'(rby_mem[k_r]) + 18'(shy_r));
              out_last <= (k_r == 5'(JOINTS - 1));
              k_r <= k_r + 5'd1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !out_valid) else $error("result while idle");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_index == 5'(JOINTS - 1))) else $error("bad last");
  a_bone_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FETCH) |-> (bone_r < 5'(BONES))) else $error("bone overrun");
endmodule
